// ----- sv/flipdot_pixel_frame_builder_assert.svh -----
// Assertion macros for the flip-dot frame builder checker
`ifndef FLIPDOT_PIXEL_FRAME_BUILDER_ASSERT_SVH
`define FLIPDOT_PIXEL_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define FPFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define FPFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fpfb_pkg.sv -----
// Types, constants and helper functions of the flip-dot pixel frame builder
package fpfb_pkg;

    localparam int MAX_MODULES = 8;
    localparam int FRAME_BYTES = 7;
    localparam int ROW_LINES   = 20;
    localparam int COL_LIMIT   = 28;
    localparam int RESET_OFS   = 20;
    localparam int ROW_BITS    = 8 * (FRAME_BYTES - 2);
    localparam int WORD_BITS   = 16 * FRAME_BYTES;
    localparam int CNT_W       = $clog2(2 * FRAME_BYTES);

    localparam logic [7:0] COL_BASE       = 8'b1111_1100;
    localparam logic [7:0] HIGH_SIDE_MASK = 8'b1111_1011;

    // Register indexes
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_COUNT    = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_COL_OFS  = 3'd3;
    localparam logic [2:0] REG_ROW_OFS  = 3'd4;
    localparam logic [2:0] REG_ADDR_TAB = 3'd5;
    localparam logic [2:0] REG_LED      = 3'd6;

    // Reset values
    localparam logic [4:0] RST_WIDTH  = 5'd28;
    localparam logic [3:0] RST_COUNT  = 4'd1;
    localparam logic [4:0] RST_HEIGHT = 5'd16;

    typedef struct packed {
        logic [4:0]  width;
        logic [3:0]  count;
        logic [4:0]  height;
        logic [4:0]  col_ofs;
        logic [4:0]  row_ofs;
        logic [63:0] addr_tab;
        logic [1:0]  led;
    } t_cfg;

    // Payload travelling through the divide stages
    typedef struct packed {
        logic [7:0] rem;
        logic [2:0] quo;
        logic [4:0] row;
        logic       on;
    } t_div;

    function automatic logic [7:0] column_byte(input logic [4:0] col,
                                               input logic       high_side,
                                               input logic [1:0] led);
        logic [1:0] q;
        logic [2:0] r;
        logic [7:0] b;
        q = (col >= 5'd21) ? 2'd3 :
            (col >= 5'd14) ? 2'd2 :
            (col >= 5'd7)  ? 2'd1 : 2'd0;
        r = 3'(col - 5'(5'(q) * 5'd7));
        b = COL_BASE | {6'd0, led};
        b = b & ~{q, 6'd0};
        b = b & ~{2'b00, 3'(r + 3'd1), 3'b000};
        if (high_side) begin
            b = b & HIGH_SIDE_MASK;
        end
        return b;
    endfunction

endpackage

// ----- sv/flipdot_pixel_frame_builder.sv -----
// Flip-dot pixel frame builder: pixel in, two seven-byte shift frames out
// A pixel passes the divide stages and the frame-pack register into the serialiser.
// Serialiser: fourteen bytes per kept pixel, one byte per cycle while i_ready is high;
//   a dropped pixel leaves the pipeline without output.
// Reset: synchronous, active low; clears all valid flags and loads register defaults.
module flipdot_pixel_frame_builder import fpfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel_x,
    input  logic [5:0]  i_pixel_y,
    input  logic        i_pixel_on,
    // byte channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_shift_byte,
    output logic        o_latch_after,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [2:0]           reg_idx;
    logic                 div_valid, div_ready;
    t_div                 div_data;
    logic                 word_valid, word_ready;
    logic [WORD_BITS-1:0] word;

    // Registers sit eight bytes apart; the low address bits pick no lane
    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= RST_WIDTH;
            r_cfg.count    <= RST_COUNT;
            r_cfg.height   <= RST_HEIGHT;
            r_cfg.col_ofs  <= 5'd0;
            r_cfg.row_ofs  <= 5'd0;
            r_cfg.addr_tab <= 64'd0;
            r_cfg.led      <= 2'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:    r_cfg.width    <= pwdata[4:0];
                REG_COUNT:    r_cfg.count    <= pwdata[3:0];
                REG_HEIGHT:   r_cfg.height   <= pwdata[4:0];
                REG_COL_OFS:  r_cfg.col_ofs  <= pwdata[4:0];
                REG_ROW_OFS:  r_cfg.row_ofs  <= pwdata[4:0];
                REG_ADDR_TAB: r_cfg.addr_tab <= pwdata;
                REG_LED:      r_cfg.led      <= pwdata[1:0];
                default: begin
                    // drop writes outside the map
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:    prdata = 64'(r_cfg.width);
            REG_COUNT:    prdata = 64'(r_cfg.count);
            REG_HEIGHT:   prdata = 64'(r_cfg.height);
            REG_COL_OFS:  prdata = 64'(r_cfg.col_ofs);
            REG_ROW_OFS:  prdata = 64'(r_cfg.row_ofs);
            REG_ADDR_TAB: prdata = r_cfg.addr_tab;
            REG_LED:      prdata = 64'(r_cfg.led);
            default:      prdata = 64'd0;
        endcase
    end

    // Bounds checks, row sum and the three quotient bits, one per stage
    fpfb_check_div u_check_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_pixel_on (i_pixel_on),
        .o_valid    (div_valid),
        .i_ready    (div_ready),
        .o_div      (div_data)
    );

    // Column check, address lookup, column and row bytes
    fpfb_frame_pack u_frame_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_div   (div_data),
        .o_valid (word_valid),
        .i_ready (word_ready),
        .o_word  (word)
    );

    // Hold each packed word here and shift it out highest byte first
    fpfb_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (word_valid),
        .o_ready       (word_ready),
        .i_word        (word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_shift_byte  (o_shift_byte),
        .o_latch_after (o_latch_after),
        .o_last        (o_last)
    );

endmodule

// ----- sv/fpfb_check_div.sv -----
// Range checks and three-stage restoring division of x by the module width
module fpfb_check_div import fpfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_pixel_x,
    input  logic [5:0] i_pixel_y,
    input  logic       i_pixel_on,
    output logic       o_valid,
    input  logic       i_ready,
    output t_div       o_div
);

    logic       r_v_b, r_v_c, r_v_d;
    t_div       r_b, r_c, r_d;
    t_div       n_b, n_c, n_d;
    logic       rdy_b, rdy_c, rdy_d;
    logic [3:0] cnt;
    logic [8:0] span;
    logic [6:0] row_sum;
    logic       ok;
    logic [7:0] d2, d1, d0;

    assign rdy_d = !r_v_d || i_ready;
    assign rdy_c = !r_v_c || rdy_d;
    assign rdy_b = !r_v_b || rdy_c;
    assign o_ready = rdy_b;

    always_comb begin
        cnt = (i_cfg.count > 4'(MAX_MODULES)) ? 4'(MAX_MODULES) : i_cfg.count;
        span = 9'(i_cfg.width) * 9'(cnt);
        row_sum = 7'(i_pixel_y) + 7'(i_cfg.row_ofs);
        ok = (i_cfg.width != 5'd0) && (cnt != 4'd0) && (9'(i_pixel_x) < span)
             && (i_pixel_y < 6'(i_cfg.height)) && (row_sum < 7'(ROW_LINES));
        // quotient bit 2
        d2 = {1'b0, i_cfg.width, 2'b00};
        n_b.row = 5'(row_sum);
        n_b.on  = i_pixel_on;
        n_b.quo = {i_pixel_x >= d2, 2'b00};
        n_b.rem = (i_pixel_x >= d2) ? 8'(i_pixel_x - d2) : i_pixel_x;
        // quotient bit 1
        d1 = {2'b00, i_cfg.width, 1'b0};
        n_c = r_b;
        n_c.quo[1] = r_b.rem >= d1;
        n_c.rem = (r_b.rem >= d1) ? 8'(r_b.rem - d1) : r_b.rem;
        // quotient bit 0
        d0 = {3'b000, i_cfg.width};
        n_d = r_c;
        n_d.quo[0] = r_c.rem >= d0;
        n_d.rem = (r_c.rem >= d0) ? 8'(r_c.rem - d0) : r_c.rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (rdy_b) begin
                r_v_b <= i_valid && ok;
            end
            if (rdy_c) begin
                r_v_c <= r_v_b;
            end
            if (rdy_d) begin
                r_v_d <= r_v_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b <= n_b;
        end
        if (rdy_c) begin
            r_c <= n_c;
        end
        if (rdy_d) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v_d;
    assign o_div   = r_d;

endmodule

// ----- sv/fpfb_frame_pack.sv -----
// Column check and assembly of the fourteen-byte word for one pixel
module fpfb_frame_pack import fpfb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_div                 i_div,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_word
);

    logic                 r_v;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 rdy;
    logic [5:0]           col;
    logic                 col_ok;
    logic [5:0]           bit_idx;
    logic [ROW_BITS-1:0]  rows;
    logic [7:0]           addr_byte;
    logic [7:0]           col_byte;
    logic [7:0]           idle_byte;

    assign rdy = !r_v || i_ready;
    assign o_ready = rdy;

    always_comb begin
        col = 6'(i_div.rem[4:0]) + 6'(i_cfg.col_ofs);
        col_ok = col < 6'(COL_LIMIT);
        bit_idx = 6'(i_div.row) + (i_div.on ? 6'd0 : 6'(RESET_OFS));
        rows = ROW_BITS'(1) << bit_idx;
        addr_byte = i_cfg.addr_tab[8*i_div.quo +: 8];
        col_byte = column_byte(col[4:0], !i_div.on, i_cfg.led);
        idle_byte = column_byte(5'd0, 1'b0, i_cfg.led);
        // drive frame, then release frame to the same module address
        n_word = {addr_byte, col_byte, rows, addr_byte, idle_byte, {ROW_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid && col_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_v;
    assign o_word  = r_word;

endmodule

// ----- sv/fpfb_serializer.sv -----
// Byte serialiser: shifts the fourteen-byte word out one byte per output handshake
module fpfb_serializer import fpfb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_shift_byte,
    output logic                 o_latch_after,
    output logic                 o_last
);

    localparam logic [CNT_W-1:0] LATCH_CNT = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(2 * FRAME_BYTES - 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_sr;
    logic                 take;
    logic                 done;
    logic                 load;

    assign take = r_busy && i_ready;
    assign done = take && (r_cnt == LAST_CNT);
    assign o_ready = !r_busy || done;
    assign load = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (take) begin
            r_cnt <= CNT_W'(r_cnt + 1'b1);
            if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sr <= i_word;
        end else if (take) begin
            r_sr <= {r_sr[WORD_BITS-9:0], 8'h00};
        end
    end

    assign o_valid       = r_busy;
    assign o_shift_byte  = r_sr[WORD_BITS-1 -: 8];
    assign o_latch_after = (r_cnt == LATCH_CNT) || (r_cnt == LAST_CNT);
    assign o_last        = r_cnt == LAST_CNT;

endmodule

// ----- sv/fpfb_checker.sv -----
// Port-level checker for the flip-dot pixel frame builder, with its bind
`include "flipdot_pixel_frame_builder_assert.svh"

module fpfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_shift_byte,
    input logic       o_latch_after,
    input logic       o_last
);

    `FPFB_ASSERT_IMPL(a_last_latches, i_clk, i_rst_n, o_valid && o_last, o_latch_after, "last byte without latch")
    `FPFB_ASSERT_IMPL(a_last_zero, i_clk, i_rst_n, o_valid && o_last, o_shift_byte == 8'h00, "release frame ends in a nonzero row byte")
    `FPFB_ASSERT_NEXT(a_release_follows, i_clk, i_rst_n, o_valid && i_ready && o_latch_after && !o_last, o_valid && !o_latch_after && !o_last, "release frame does not follow drive frame")
    `FPFB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_shift_byte) && $stable(o_last), "stalled byte changed")

endmodule

bind flipdot_pixel_frame_builder fpfb_checker u_fpfb_checker (.*);
